// ===== rtl/core/counter_priority_task_scheduler_defines.svh =====
// Assertion macros used by the checker file of the scheduler.
`ifndef COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define COUNTER_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/cpts_pkg.sv =====
package cpts_pkg;

	// Port widths of the request and result fields.
	localparam int REQ_W     = 3;
	localparam int SLOT_W    = 6;
	localparam int PRIO_IN_W = 8;
	localparam int CNT_IN_W  = 16;
	localparam int PRE_W     = 8;

	localparam logic [PRE_W-1:0] PREEMPT_MAX = 8'hFF;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK     = 3'd0,
		REQ_YIELD    = 3'd1,
		REQ_WRITE    = 3'd2,
		REQ_PRE_DIS  = 3'd3,
		REQ_PRE_EN   = 3'd4
	} req_t;

endpackage

// ===== rtl/core/counter_priority_task_scheduler.sv =====
// Channel   Handshake            Fields
// request   start / busy         req_type slot slot_present slot_runnable slot_priority
//                                slot_counter slot_preempt
// result    done (one cycle)     current_task switched stalled current_counter
//
// One beat in, one beat out. Write, preempt and unknown requests, and ticks that do not
// reschedule, go to the report read and wait states without a scan.
// A reschedule runs scan passes over the task memory, which has one read and one write
// port, with a recharge pass between scans and at most (COUNTER_BITS + 8) recharges.
// Reset clears control state only; busy stays high from the accepting edge until the
// cycle before done, and done cannot be held off.
module counter_priority_task_scheduler #(
	parameter int TASK_SLOTS    = 64,
	parameter int PRIORITY_BITS = 8,
	parameter int COUNTER_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [cpts_pkg::REQ_W-1:0]           req_type,
	input  logic [cpts_pkg::SLOT_W-1:0]          slot,
	input  logic                                 slot_present,
	input  logic                                 slot_runnable,
	input  logic [cpts_pkg::PRIO_IN_W-1:0]       slot_priority,
	input  logic signed [cpts_pkg::CNT_IN_W-1:0] slot_counter,
	input  logic [cpts_pkg::PRE_W-1:0]           slot_preempt,
	output logic                                 done,
	output logic [cpts_pkg::SLOT_W-1:0]          current_task,
	output logic                                 switched,
	output logic                                 stalled,
	output logic signed [cpts_pkg::CNT_IN_W-1:0] current_counter
);
	import cpts_pkg::*;

	localparam int IW        = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int IDX_W     = IW + 1;
	localparam int CB        = COUNTER_BITS;
	localparam int PB        = PRIORITY_BITS;
	localparam int SW        = ((CB > PB) ? CB : PB + 1) + 1;
	localparam int XW        = (CB > CNT_IN_W) ? CB : CNT_IN_W;
	localparam int REC_LIMIT = CB + 8;
	localparam int ITER_W    = $clog2(REC_LIMIT);

	localparam logic [IDX_W-1:0]     IDX_END   = IDX_W'(TASK_SLOTS);
	localparam logic [ITER_W-1:0]    ITER_LAST = ITER_W'(REC_LIMIT - 1);
	localparam logic signed [CB-1:0] CNT_MAX   = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] CNT_MIN   = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] CNT_ONE   = CB'(1);
	localparam logic signed [CB-1:0] CNT_NEG1  = {CB{1'b1}};

	typedef struct packed {
		logic [PB-1:0]    prio;
		logic [CB-1:0]    cnt;
		logic [PRE_W-1:0] pre;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CUR_RD,
		ST_MODIFY,
		ST_WRITE,
		ST_SCAN,
		ST_RECHARGE,
		ST_RPT_RD,
		ST_RPT_WAIT
	} state_t;

	function automatic logic signed [CB-1:0] sat_in(logic signed [CNT_IN_W-1:0] v);
		logic signed [XW-1:0] x;
		logic signed [CB-1:0] r;
		x = XW'(v);
		if (x > XW'(CNT_MAX)) begin
			r = CNT_MAX;
		end else if (x < XW'(CNT_MIN)) begin
			r = CNT_MIN;
		end else begin
			r = CB'(x);
		end
		return r;
	endfunction

	// floor(c / 2) + priority, clamped to the counter range.
	function automatic logic signed [CB-1:0] recharge(logic signed [CB-1:0] c,
			logic [PB-1:0] p);
		logic signed [CB-1:0] h;
		logic signed [SW-1:0] s;
		logic signed [CB-1:0] r;
		h = c >>> 1;
		s = SW'(h) + $signed({{(SW-PB){1'b0}}, p});
		if (s > SW'(CNT_MAX)) begin
			r = CNT_MAX;
		end else if (s < SW'(CNT_MIN)) begin
			r = CNT_MIN;
		end else begin
			r = CB'(s);
		end
		return r;
	endfunction

	state_t                  state_q;
	logic                    busy_q;
	logic                    done_q;
	logic [REQ_W-1:0]        req_q;
	logic [SLOT_W-1:0]       slot_q;
	logic                    pres_in_q;
	logic                    run_in_q;
	logic [PRIO_IN_W-1:0]    prio_in_q;
	logic signed [CNT_IN_W-1:0] cnt_in_q;
	logic [PRE_W-1:0]        pre_in_q;
	logic [IW-1:0]           cur_q;
	logic [IW-1:0]           old_q;
	logic                    stall_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    pend_q;
	logic [IW-1:0]           pidx_q;
	logic signed [CB-1:0]    best_q;
	logic [IW-1:0]           pick_q;
	logic                    anyp_q;
	logic [ITER_W-1:0]       iter_q;
	logic [TASK_SLOTS-1:0]   present_q;
	logic [TASK_SLOTS-1:0]   runnable_q;
	logic [TASK_SLOTS-1:0]   written_q;
	logic [SLOT_W-1:0]       current_task_q;
	logic                    switched_q;
	logic                    stalled_q;
	logic signed [CNT_IN_W-1:0] current_counter_q;

	entry_t                  task_mem [TASK_SLOTS];
	entry_t                  rdata_q;
	logic                    rvalid_q;
	logic                    rzero_q;
	logic                    rpres_q;
	logic                    rrun_q;

	logic [IW-1:0]           raddr;
	logic                    we;
	logic [IW-1:0]           waddr;
	entry_t                  wdata;
	entry_t                  rd_ent;
	logic signed [CB-1:0]    rd_cnt;
	logic signed [CB-1:0]    c_dec;
	logic                    tick_resched;
	logic                    slot_ok;
	entry_t                  mod_ent;

	assign busy            = busy_q;
	assign done            = done_q;
	assign current_task    = current_task_q;
	assign switched        = switched_q;
	assign stalled         = stalled_q;
	assign current_counter = current_counter_q;

	assign slot_ok = (32'(slot_q) < 32'(TASK_SLOTS));

	// A never-written entry reads as its reset value: slot 0 has priority one.
	always_comb begin
		if (rvalid_q) begin
			rd_ent = rdata_q;
		end else begin
			rd_ent      = '0;
			rd_ent.prio = rzero_q ? PB'(1) : '0;
		end
		rd_cnt = $signed(rd_ent.cnt);
	end

	always_comb begin
		c_dec        = (rd_cnt == CNT_MIN) ? CNT_MIN : rd_cnt - CNT_ONE;
		tick_resched = !((!c_dec[CB-1] && c_dec != '0) || rd_ent.pre != '0);
		mod_ent      = rd_ent;
		case (req_q)
			REQ_TICK: begin
				mod_ent.cnt = tick_resched ? '0 : c_dec;
			end
			REQ_YIELD: begin
				mod_ent.cnt = '0;
			end
			REQ_PRE_DIS: begin
				if (rd_ent.pre != PREEMPT_MAX) begin
					mod_ent.pre = rd_ent.pre + PRE_W'(1);
				end
			end
			REQ_PRE_EN: begin
				if (rd_ent.pre != '0) begin
					mod_ent.pre = rd_ent.pre - PRE_W'(1);
				end
			end
			default: begin
				mod_ent = rd_ent;
			end
		endcase
	end

	always_comb begin
		raddr = cur_q;
		we    = 1'b0;
		waddr = cur_q;
		wdata = mod_ent;
		case (state_q)
			ST_SCAN: begin
				raddr = idx_q[IW-1:0];
			end
			ST_RECHARGE: begin
				raddr     = idx_q[IW-1:0];
				we        = pend_q && rpres_q;
				waddr     = pidx_q;
				wdata     = rd_ent;
				wdata.cnt = recharge(rd_cnt, rd_ent.prio);
			end
			ST_MODIFY: begin
				we = 1'b1;
			end
			ST_WRITE: begin
				we         = slot_ok;
				waddr      = IW'(slot_q);
				wdata.prio = PB'(prio_in_q);
				wdata.cnt  = sat_in(cnt_in_q);
				wdata.pre  = pre_in_q;
			end
			default: begin
				raddr = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			task_mem[waddr] <= wdata;
		end
		rdata_q  <= task_mem[raddr];
		rvalid_q <= written_q[raddr];
		rzero_q  <= (raddr == '0);
		rpres_q  <= present_q[raddr];
		rrun_q   <= runnable_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			busy_q            <= 1'b0;
			done_q            <= 1'b0;
			cur_q             <= '0;
			old_q             <= '0;
			stall_q           <= 1'b0;
			idx_q             <= '0;
			pend_q            <= 1'b0;
			pidx_q            <= '0;
			best_q            <= CNT_NEG1;
			pick_q            <= '0;
			anyp_q            <= 1'b0;
			iter_q            <= '0;
			present_q         <= TASK_SLOTS'(1);
			runnable_q        <= '0;
			written_q         <= '0;
			current_task_q    <= '0;
			switched_q        <= 1'b0;
			stalled_q         <= 1'b0;
			current_counter_q <= '0;
		end else begin
			done_q <= (state_q == ST_RPT_WAIT);
			if (we) begin
				written_q[waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q     <= req_type;
						slot_q    <= slot;
						pres_in_q <= slot_present;
						run_in_q  <= slot_runnable;
						prio_in_q <= slot_priority;
						cnt_in_q  <= slot_counter;
						pre_in_q  <= slot_preempt;
						old_q     <= cur_q;
						stall_q   <= 1'b0;
						busy_q    <= 1'b1;
						case (req_type)
							REQ_TICK, REQ_YIELD, REQ_PRE_DIS, REQ_PRE_EN: begin
								state_q <= ST_CUR_RD;
							end
							REQ_WRITE: begin
								state_q <= ST_WRITE;
							end
							default: begin
								state_q <= ST_RPT_RD;
							end
						endcase
					end
				end
				ST_CUR_RD: begin
					state_q <= ST_MODIFY;
				end
				ST_MODIFY: begin
					if ((req_q == REQ_TICK && tick_resched) || req_q == REQ_YIELD) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						pend_q  <= 1'b0;
						best_q  <= CNT_NEG1;
						pick_q  <= '0;
						anyp_q  <= 1'b0;
						iter_q  <= '0;
					end else begin
						state_q <= ST_RPT_RD;
					end
				end
				ST_WRITE: begin
					if (slot_ok) begin
						present_q[IW'(slot_q)]  <= pres_in_q;
						runnable_q[IW'(slot_q)] <= run_in_q;
					end
					state_q <= ST_RPT_RD;
				end
				ST_SCAN: begin
					if (idx_q != IDX_END) begin
						pend_q <= 1'b1;
						pidx_q <= idx_q[IW-1:0];
						idx_q  <= idx_q + IDX_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
					// Strictly greater keeps the lowest index on ties.
					if (pend_q && rpres_q && rrun_q) begin
						if (rd_ent.prio != '0) begin
							anyp_q <= 1'b1;
						end
						if (rd_cnt > best_q) begin
							best_q <= rd_cnt;
							pick_q <= pidx_q;
						end
					end
					if (idx_q == IDX_END && !pend_q) begin
						if (best_q != '0) begin
							cur_q   <= pick_q;
							state_q <= ST_RPT_RD;
						end else if (!anyp_q) begin
							stall_q <= 1'b1;
							state_q <= ST_RPT_RD;
						end else begin
							idx_q   <= '0;
							state_q <= ST_RECHARGE;
						end
					end
				end
				ST_RECHARGE: begin
					if (idx_q != IDX_END) begin
						pend_q <= 1'b1;
						pidx_q <= idx_q[IW-1:0];
						idx_q  <= idx_q + IDX_W'(1);
					end else begin
						pend_q <= 1'b0;
					end
					if (idx_q == IDX_END && !pend_q) begin
						if (iter_q == ITER_LAST) begin
							stall_q <= 1'b1;
							state_q <= ST_RPT_RD;
						end else begin
							iter_q  <= iter_q + ITER_W'(1);
							idx_q   <= '0;
							best_q  <= CNT_NEG1;
							pick_q  <= '0;
							anyp_q  <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RPT_RD: begin
					state_q <= ST_RPT_WAIT;
				end
				ST_RPT_WAIT: begin
					current_task_q    <= SLOT_W'(cur_q);
					switched_q        <= (cur_q != old_q);
					stalled_q         <= stall_q;
					current_counter_q <= CNT_IN_W'(rd_cnt);
					busy_q            <= 1'b0;
					state_q           <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/cpts_checker.sv =====
`include "counter_priority_task_scheduler_defines.svh"

module cpts_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic [cpts_pkg::REQ_W-1:0]           req_type,
	input logic [cpts_pkg::SLOT_W-1:0]          slot,
	input logic                                 slot_present,
	input logic                                 slot_runnable,
	input logic [cpts_pkg::PRIO_IN_W-1:0]       slot_priority,
	input logic signed [cpts_pkg::CNT_IN_W-1:0] slot_counter,
	input logic [cpts_pkg::PRE_W-1:0]           slot_preempt,
	input logic                                 done,
	input logic [cpts_pkg::SLOT_W-1:0]          current_task,
	input logic                                 switched,
	input logic                                 stalled,
	input logic signed [cpts_pkg::CNT_IN_W-1:0] current_counter
);
	import cpts_pkg::*;

	// Every accepted beat makes the block busy in the following cycle.
	`CPTS_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accept did not raise busy")

	// Busy drops exactly when the result beat is shown.
	`CPTS_ASSERT_SAME(a_fall_done, clk, arst_n, $fell(busy), done, "busy fell without a result")

	// A stall keeps the current task.
	`CPTS_ASSERT_SAME(a_stall_keep, clk, arst_n, done && stalled, !switched,
		"stalled result reports a switch")

	// Without a switch the reported task is the one reported last time.
	`CPTS_ASSERT_SAME(a_same_task, clk, arst_n, done && !switched,
		current_task == $past(current_task), "task changed without switched")

endmodule

bind counter_priority_task_scheduler cpts_checker u_cpts_checker (.*);

// ===== tb/sv/tb_counter_priority_task_scheduler.sv =====
`timescale 1ns / 1ps

module tb_counter_priority_task_scheduler;
	import cpts_pkg::*;

	localparam int SLOTS           = 64;
	localparam int RECHARGE_PASSES = 16 + 8;
	localparam int CNT_MAX         = 32767;
	localparam int CNT_MIN         = -32768;
	localparam int RANDOM_ITEMS    = 1526;
	localparam int TAIL_CYCLES     = 16;
	localparam logic [REQ_W-1:0] REQ_LAST_CODE = '1;

	typedef struct {
		logic [REQ_W-1:0]           kind;
		logic [SLOT_W-1:0]          slot;
		logic                       pres;
		logic                       runn;
		logic [PRIO_IN_W-1:0]       prio;
		logic signed [CNT_IN_W-1:0] cnt;
		logic [PRE_W-1:0]           pre;
	} sched_req_t;

	typedef struct {
		logic [SLOT_W-1:0]          task_idx;
		logic                       sw;
		logic                       st;
		logic signed [CNT_IN_W-1:0] ctr;
	} sched_res_t;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [REQ_W-1:0]           req_type;
	logic [SLOT_W-1:0]          slot;
	logic                       slot_present;
	logic                       slot_runnable;
	logic [PRIO_IN_W-1:0]       slot_priority;
	logic signed [CNT_IN_W-1:0] slot_counter;
	logic [PRE_W-1:0]           slot_preempt;
	logic                       done;
	logic [SLOT_W-1:0]          current_task;
	logic                       switched;
	logic                       stalled;
	logic signed [CNT_IN_W-1:0] current_counter;

	counter_priority_task_scheduler u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.slot           (slot),
		.slot_present   (slot_present),
		.slot_runnable  (slot_runnable),
		.slot_priority  (slot_priority),
		.slot_counter   (slot_counter),
		.slot_preempt   (slot_preempt),
		.done           (done),
		.current_task   (current_task),
		.switched       (switched),
		.stalled        (stalled),
		.current_counter(current_counter)
	);

	// Shadow copy of the task table.
	bit                         present_q  [SLOTS];
	bit                         runnable_q [SLOTS];
	logic [PRIO_IN_W-1:0]       prio_q     [SLOTS];
	logic signed [CNT_IN_W-1:0] slice_q    [SLOTS];
	logic [PRE_W-1:0]           preempt_q  [SLOTS];
	logic [SLOT_W-1:0]          running_q;

	sched_req_t pending_reqs[$];
	sched_res_t expected_picks[$];
	sched_req_t on_bus;
	bit         beat_taken;
	int         n_items;
	int         launched;
	int         mismatches;
	int         idle_pct [4] = '{0, 78, 0, 37};

	always #6 clk = ~clk;

	function automatic logic signed [CNT_IN_W-1:0] clamp_slice(int v);
		if (v > CNT_MAX)
			return CNT_IN_W'(CNT_MAX);
		if (v < CNT_MIN)
			return CNT_IN_W'(CNT_MIN);
		return CNT_IN_W'(v);
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < SLOTS; i++) begin
			present_q[i]  = 0;
			runnable_q[i] = 0;
			prio_q[i]     = '0;
			slice_q[i]    = '0;
			preempt_q[i]  = '0;
		end
		present_q[0] = 1;
		prio_q[0]    = 1;
		running_q    = '0;
	endfunction

	// Returns 1 when no choice can be made and the running task is kept.
	function automatic bit pick_next_task();
		int best;
		logic [SLOT_W-1:0] pick;
		bit any_prio;
		for (int pass = 0; pass < RECHARGE_PASSES; pass++) begin
			best = -1;
			pick = '0;
			any_prio = 0;
			for (int i = 0; i < SLOTS; i++) begin
				if (present_q[i] && runnable_q[i]) begin
					if (prio_q[i] != 0)
						any_prio = 1;
					if (int'(slice_q[i]) > best) begin
						best = int'(slice_q[i]);
						pick = SLOT_W'(i);
					end
				end
			end
			if (best != 0) begin
				running_q = pick;
				return 0;
			end
			if (!any_prio)
				return 1;
			// Recharge pass: floor of half the slice plus the priority.
			for (int i = 0; i < SLOTS; i++)
				if (present_q[i])
					slice_q[i] = clamp_slice((int'(slice_q[i]) >>> 1) + int'(prio_q[i]));
		end
		return 1;
	endfunction

	function automatic sched_res_t predict_schedule(sched_req_t r);
		logic [SLOT_W-1:0] prior;
		bit stall;
		sched_res_t res;
		prior = running_q;
		stall = 0;
		case (r.kind)
			REQ_TICK: begin
				slice_q[prior] = clamp_slice(int'(slice_q[prior]) - 1);
				if (!(slice_q[prior] > 0 || preempt_q[prior] != 0)) begin
					slice_q[prior] = '0;
					stall = pick_next_task();
				end
			end
			REQ_YIELD: begin
				slice_q[prior] = '0;
				stall = pick_next_task();
			end
			REQ_WRITE: begin
				present_q[r.slot]  = r.pres;
				runnable_q[r.slot] = r.runn;
				prio_q[r.slot]     = r.prio;
				slice_q[r.slot]    = r.cnt;
				preempt_q[r.slot]  = r.pre;
			end
			REQ_PRE_DIS: begin
				if (preempt_q[prior] != PREEMPT_MAX)
					preempt_q[prior] = preempt_q[prior] + 1'b1;
			end
			REQ_PRE_EN: begin
				if (preempt_q[prior] != 0)
					preempt_q[prior] = preempt_q[prior] - 1'b1;
			end
			default: ;
		endcase
		res.task_idx = running_q;
		res.sw       = (running_q != prior);
		res.st       = stall;
		res.ctr      = slice_q[running_q];
		return res;
	endfunction

	function automatic sched_req_t make_req(logic [REQ_W-1:0] kind, int s, bit pres, bit runn,
			int prio, int cnt, int pre);
		sched_req_t r;
		r.kind = kind;
		r.slot = SLOT_W'(s);
		r.pres = pres;
		r.runn = runn;
		r.prio = PRIO_IN_W'(prio);
		r.cnt  = CNT_IN_W'(cnt);
		r.pre  = PRE_W'(pre);
		return r;
	endfunction

	function automatic sched_req_t random_req();
		sched_req_t r;
		int pick;
		int edge_vals [7] = '{CNT_MAX, CNT_MIN, CNT_MAX - 1, CNT_MIN + 1, 0, 1, -1};
		pick = $urandom_range(99, 0);
		if (pick < 35)
			r.kind = REQ_TICK;
		else if (pick < 50)
			r.kind = REQ_YIELD;
		else if (pick < 80)
			r.kind = REQ_WRITE;
		else if (pick < 87)
			r.kind = REQ_PRE_DIS;
		else if (pick < 95)
			r.kind = REQ_PRE_EN;
		else
			r.kind = REQ_PRE_EN + REQ_W'($urandom_range(REQ_LAST_CODE - REQ_PRE_EN, 1));
		// Most writes land in a few low slots so that the tasks compete.
		r.slot = ($urandom_range(99, 0) < 75) ? SLOT_W'($urandom_range(7, 0)) : SLOT_W'($urandom);
		r.pres = ($urandom_range(99, 0) < 85);
		r.runn = ($urandom_range(99, 0) < 75);
		pick = $urandom_range(99, 0);
		if (pick < 20)
			r.prio = '0;
		else if (pick < 70)
			r.prio = PRIO_IN_W'($urandom_range(8, 1));
		else if (pick < 90)
			r.prio = PRIO_IN_W'($urandom);
		else
			r.prio = '1;
		pick = $urandom_range(99, 0);
		if (pick < 60)
			r.cnt = CNT_IN_W'(int'($urandom_range(24, 0)) - 4);
		else if (pick < 85)
			r.cnt = CNT_IN_W'($urandom);
		else
			r.cnt = CNT_IN_W'(edge_vals[$urandom_range(6, 0)]);
		pick = $urandom_range(99, 0);
		if (pick < 70)
			r.pre = '0;
		else if (pick < 85)
			r.pre = PRE_W'($urandom_range(3, 1));
		else if (pick < 95)
			r.pre = PRE_W'($urandom);
		else
			r.pre = PREEMPT_MAX - PRE_W'($urandom_range(1, 0));
		return r;
	endfunction

	initial begin
		clk           = 0;
		arst_n        = 0;
		start         = 0;
		req_type      = REQ_TICK;
		slot          = '0;
		slot_present  = 0;
		slot_runnable = 0;
		slot_priority = '0;
		slot_counter  = '0;
		slot_preempt  = '0;
		beat_taken    = 0;
		launched      = 0;
		mismatches    = 0;
		clear_table();

		// Directed part: idle table, preempt limits, absent current slot, the stall,
		// counter extremes and a reschedule that needs many recharges.
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_LAST_CODE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 0, 1, 0, 1, 5, 254));
		pending_reqs.push_back(make_req(REQ_PRE_DIS, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_PRE_DIS, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 0, 1, 0, 1, 1, 1));
		pending_reqs.push_back(make_req(REQ_PRE_EN, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_PRE_EN, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 1, 1, 1, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 63, 1, 1, 255, CNT_MIN, 255));
		pending_reqs.push_back(make_req(REQ_WRITE, 2, 1, 1, 255, CNT_MAX, 0));
		pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 2, 1, 1, 1, CNT_MIN, 0));
		pending_reqs.push_back(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 5, 0, 1, 255, 100, 0));
		pending_reqs.push_back(make_req(REQ_YIELD, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(REQ_WRITE, 0, 1, 0, 1, 0, 0));
		pending_reqs.push_back(make_req(REQ_PRE_EN + 1'b1, 0, 0, 0, 0, 0, 0));
		repeat (RANDOM_ITEMS)
			pending_reqs.push_back(random_req());
		n_items = pending_reqs.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#250_000_000;
		$display("simulation failed");
		$finish;
	end

	// Request driver: a new beat is presented only once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!start || beat_taken)) begin
			beat_taken = 0;
			if (pending_reqs.size() != 0
					&& $urandom_range(99, 0) >= idle_pct[(launched * 4) / n_items]) begin
				on_bus = pending_reqs.pop_front();
				launched++;
				req_type      <= on_bus.kind;
				slot          <= on_bus.slot;
				slot_present  <= on_bus.pres;
				slot_runnable <= on_bus.runn;
				slot_priority <= on_bus.prio;
				slot_counter  <= on_bus.cnt;
				slot_preempt  <= on_bus.pre;
				start         <= 1;
			end else begin
				start <= 0;
			end
		end
	end

	// Result monitor, and prediction of each request beat as it is accepted.
	always @(posedge clk) begin
		sched_res_t exp_res;
		if (arst_n) begin
			if (done) begin
				if (expected_picks.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: task %0d switched %0b stalled %0b counter %0d",
							current_task, switched, stalled, current_counter);
				end else begin
					exp_res = expected_picks.pop_front();
					if (current_task !== exp_res.task_idx || switched !== exp_res.sw
							|| stalled !== exp_res.st || current_counter !== exp_res.ctr) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("result mismatch: expected task %0d switched %0b stalled %0b",
								exp_res.task_idx, exp_res.sw, exp_res.st);
							$display(" counter %0d, got task %0d switched %0b stalled %0b counter %0d",
								exp_res.ctr, current_task, switched, stalled, current_counter);
						end
					end
				end
			end
			if (start && !busy) begin
				expected_picks.push_back(predict_schedule(on_bus));
				beat_taken = 1;
			end
		end
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cpts_pkg.sv
rtl/core/counter_priority_task_scheduler.sv
rtl/core/cpts_checker.sv
tb/sv/tb_counter_priority_task_scheduler.sv
